[src/mrdn_pkg.sv]
// shared types, constants and radix helpers for the mixed-radix date normalizer
`default_nettype none

package mrdn_pkg;

    localparam int DIGIT_BITS   = 24;
    localparam int IO_BITS      = 24;
    localparam int NUM_DIGITS   = 9;
    localparam int LOW_RADIX    = 20;
    localparam int SECOND_RADIX = 18;
    localparam int UPPER_RADIX  = 20;

    localparam int IDX_BITS    = $clog2(NUM_DIGITS);
    localparam int SUM_BITS    = DIGIT_BITS + 2;
    localparam int RADIX_BITS  = 9;
    localparam int RECIP_SHIFT = SUM_BITS + 5;
    localparam int RECIP_BITS  = RECIP_SHIFT;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS + 1;
    localparam int WIDE_BITS   = SUM_BITS + RADIX_BITS + 1;

    localparam logic [RECIP_BITS-1:0] LOW_RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / LOW_RADIX);
    localparam logic [RECIP_BITS-1:0] SECOND_RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / SECOND_RADIX);
    localparam logic [RECIP_BITS-1:0] UPPER_RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / UPPER_RADIX);

    localparam logic [IDX_BITS-1:0] LAST_LOWER_IDX = IDX_BITS'(NUM_DIGITS - 2);
    localparam logic [IDX_BITS-1:0] TOP_IDX        = IDX_BITS'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_CARRY = 2'd1,
        KIND_CLAMP = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [IO_BITS-1:0]     in_kin;
        logic signed [IO_BITS-1:0]     in_uinal;
        logic signed [IO_BITS-1:0]     in_tun;
        logic signed [IO_BITS-1:0]     in_katun;
        logic signed [IO_BITS-1:0]     in_baktun;
        logic signed [IO_BITS-1:0]     in_pictun;
        logic signed [IO_BITS-1:0]     in_calabtun;
        logic signed [IO_BITS-1:0]     in_kinchiltun;
        logic signed [IO_BITS-1:0]     in_alautun;
    } mrdn_in_t;

    typedef struct packed {
        logic signed [IO_BITS-1:0]     out_kin;
        logic signed [IO_BITS-1:0]     out_uinal;
        logic signed [IO_BITS-1:0]     out_tun;
        logic signed [IO_BITS-1:0]     out_katun;
        logic signed [IO_BITS-1:0]     out_baktun;
        logic signed [IO_BITS-1:0]     out_pictun;
        logic signed [IO_BITS-1:0]     out_calabtun;
        logic signed [IO_BITS-1:0]     out_kinchiltun;
        logic signed [IO_BITS-1:0]     out_alautun;
        logic                          all_in_range;
    } mrdn_out_t;

    typedef struct packed {
        logic                          load;
        logic                          clamp;
        logic [IDX_BITS-1:0]           idx;
        logic signed [SUM_BITS-1:0]    sum;
    } mrdn_req_t;

    typedef struct packed {
        logic signed [DIGIT_BITS-1:0]  digit;
        logic signed [SUM_BITS-1:0]    carry;
    } mrdn_rsp_t;

    function automatic logic [RADIX_BITS-1:0] radix_of(input logic [IDX_BITS-1:0] idx);
        logic [RADIX_BITS-1:0] r;
        case (idx)
            IDX_BITS'(0): r = RADIX_BITS'(LOW_RADIX);
            IDX_BITS'(1): r = RADIX_BITS'(SECOND_RADIX);
            default:      r = RADIX_BITS'(UPPER_RADIX);
        endcase
        return r;
    endfunction

    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [IDX_BITS-1:0] idx);
        logic [RECIP_BITS-1:0] m;
        case (idx)
            IDX_BITS'(0): m = LOW_RECIP;
            IDX_BITS'(1): m = SECOND_RECIP;
            default:      m = UPPER_RECIP;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[src/mrdn_digit_unit.sv]
// shared floor divide by radix with remainder, or clamp into 0 to radix-1
`default_nettype none

module mrdn_digit_unit (
    input  wire logic                aclk,
    input  wire mrdn_pkg::mrdn_req_t req,
    output mrdn_pkg::mrdn_rsp_t      rsp
);
    import mrdn_pkg::*;

    logic signed [SUM_BITS-1:0]   sum_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic [RADIX_BITS-1:0]        radix_reg;
    logic                         clamp_reg;

    logic signed [SUM_BITS-1:0]   q_est;
    logic signed [WIDE_BITS-1:0]  sum_w;
    logic signed [WIDE_BITS-1:0]  radix_w;
    logic signed [WIDE_BITS-1:0]  q_r;
    logic signed [WIDE_BITS-1:0]  rem;
    logic signed [DIGIT_BITS-1:0] digit_c;
    logic signed [SUM_BITS-1:0]   carry_c;

    always_ff @(posedge aclk) begin
        if (req.load) begin
            sum_reg   <= req.sum;
            prod_reg  <= req.sum * $signed({1'b0, recip_of(req.idx)});
            radix_reg <= radix_of(req.idx);
            clamp_reg <= req.clamp;
        end
    end

    // quotient estimate is the floor or one off it in either direction; the remainder check corrects it
    assign q_est   = prod_reg[RECIP_SHIFT +: SUM_BITS];
    assign sum_w   = WIDE_BITS'(sum_reg);
    assign radix_w = WIDE_BITS'($signed({1'b0, radix_reg}));
    assign q_r     = WIDE_BITS'(q_est) * radix_w;
    assign rem     = sum_w - q_r;

    always_comb begin
        if (clamp_reg) begin
            carry_c = '0;
            if (sum_reg < 0) begin
                digit_c = '0;
            end else if (sum_w >= radix_w) begin
                digit_c = DIGIT_BITS'(radix_w - WIDE_BITS'(1));
            end else begin
                digit_c = DIGIT_BITS'(sum_reg);
            end
        end else if (rem < 0) begin
            digit_c = DIGIT_BITS'(rem + radix_w);
            carry_c = q_est - SUM_BITS'(1);
        end else if (rem >= radix_w) begin
            digit_c = DIGIT_BITS'(rem - radix_w);
            carry_c = q_est + SUM_BITS'(1);
        end else begin
            digit_c = DIGIT_BITS'(rem);
            carry_c = q_est;
        end
    end

    assign rsp.digit = digit_c;
    assign rsp.carry = carry_c;

endmodule

`default_nettype wire

[src/mixed_radix_date_normalizer_top.sv]
// top level: digit store, sequencer over the shared digit unit, output register
// load and no-op items go from idle to the finish state, which fills the output register and
// raises m_valid once that register is free; carry and clamp items pass each lower digit
// through the sum and normalize states of the shared floor-divide unit, then top and finish;
// new items are taken only in idle, also while a result waits in the output register
// synchronous active-low reset clears the digit store to zero and drops m_valid
`default_nettype none

module mixed_radix_date_normalizer_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mrdn_pkg::mrdn_in_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mrdn_pkg::mrdn_out_t      m_item
);
    import mrdn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_NORM = 5'b00100,
        ST_TOP  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_BITS-1:0]          idx_reg;
    logic                         clamp_reg;
    logic signed [SUM_BITS-1:0]   carry_reg;
    logic signed [IO_BITS-1:0]    off_reg   [NUM_DIGITS];
    logic signed [DIGIT_BITS-1:0] digit_reg [NUM_DIGITS];
    mrdn_out_t                    out_reg;
    logic                         m_valid_reg;

    logic signed [IO_BITS-1:0]    in_vals [NUM_DIGITS];
    logic                         s_xfer;
    logic                         out_free;
    logic                         in_range;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [DIGIT_BITS-1:0] top_sum;
    mrdn_req_t                    req;
    mrdn_rsp_t                    rsp;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = out_reg;

    assign in_vals[0] = s_item.in_kin;
    assign in_vals[1] = s_item.in_uinal;
    assign in_vals[2] = s_item.in_tun;
    assign in_vals[3] = s_item.in_katun;
    assign in_vals[4] = s_item.in_baktun;
    assign in_vals[5] = s_item.in_pictun;
    assign in_vals[6] = s_item.in_calabtun;
    assign in_vals[7] = s_item.in_kinchiltun;
    assign in_vals[8] = s_item.in_alautun;

    assign sum = SUM_BITS'(digit_reg[idx_reg]) + SUM_BITS'(off_reg[idx_reg]) + carry_reg;
    assign top_sum = digit_reg[TOP_IDX] + DIGIT_BITS'(off_reg[TOP_IDX])
                   + DIGIT_BITS'(carry_reg);

    assign req.load  = (state_reg == ST_SUM);
    assign req.clamp = clamp_reg;
    assign req.idx   = idx_reg;
    assign req.sum   = sum;

    mrdn_digit_unit u_digit_unit (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    always_comb begin
        in_range = 1'b1;
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            if (digit_reg[i][DIGIT_BITS-1] ||
                (digit_reg[i] >= $signed(DIGIT_BITS'(radix_of(IDX_BITS'(i)))))) begin
                in_range = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.kind == KIND_CARRY || s_item.kind == KIND_CLAMP) begin
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SUM: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                state_next = (idx_reg == LAST_LOWER_IDX) ? ST_TOP : ST_SUM;
            end
            ST_TOP: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // digit store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_reg[i] <= '0;
            end
        end else begin
            if (s_xfer && s_item.kind == KIND_LOAD) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digit_reg[i] <= DIGIT_BITS'(in_vals[i]);
                end
            end
            if (state_reg == ST_NORM) begin
                digit_reg[idx_reg] <= rsp.digit;
            end
            if (state_reg == ST_TOP) begin
                digit_reg[TOP_IDX] <= top_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                off_reg[i] <= in_vals[i];
            end
            clamp_reg <= (s_item.kind == KIND_CLAMP);
            idx_reg   <= '0;
            carry_reg <= '0;
        end
        if (state_reg == ST_NORM) begin
            carry_reg <= clamp_reg ? '0 : rsp.carry;
            if (idx_reg != LAST_LOWER_IDX) begin
                idx_reg <= idx_reg + IDX_BITS'(1);
            end
        end
        if (state_reg == ST_FIN && out_free) begin
            out_reg.out_kin        <= IO_BITS'(digit_reg[0]);
            out_reg.out_uinal      <= IO_BITS'(digit_reg[1]);
            out_reg.out_tun        <= IO_BITS'(digit_reg[2]);
            out_reg.out_katun      <= IO_BITS'(digit_reg[3]);
            out_reg.out_baktun     <= IO_BITS'(digit_reg[4]);
            out_reg.out_pictun     <= IO_BITS'(digit_reg[5]);
            out_reg.out_calabtun   <= IO_BITS'(digit_reg[6]);
            out_reg.out_kinchiltun <= IO_BITS'(digit_reg[7]);
            out_reg.out_alautun    <= IO_BITS'(digit_reg[8]);
            out_reg.all_in_range   <= in_range;
        end
    end

endmodule

`default_nettype wire

[dv/mixed_radix_date_normalizer_checker.sv]
// checker for the mixed-radix date normalizer: tracks the held date, predicts and compares
module mixed_radix_date_normalizer_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire mrdn_pkg::mrdn_in_t  s_item,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire mrdn_pkg::mrdn_out_t m_item,
    output int                       pending_results,
    output int                       fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrdn_pkg::*;

    logic signed [DIGIT_BITS-1:0] held_digits [NUM_DIGITS];
    mrdn_out_t                    expected_dates [$];
    string digit_names [NUM_DIGITS] = '{"out_kin", "out_uinal", "out_tun", "out_katun",
        "out_baktun", "out_pictun", "out_calabtun", "out_kinchiltun", "out_alautun"};

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    function automatic longint radix_at(input int i);
        if (i == 0) begin
            return LOW_RADIX;
        end
        if (i == 1) begin
            return SECOND_RADIX;
        end
        return UPPER_RADIX;
    endfunction

    function automatic longint offset_at(input mrdn_in_t it, input int i);
        return longint'(signed'(it[IO_BITS*(NUM_DIGITS-1-i) +: IO_BITS]));
    endfunction

    function automatic longint out_digit(input mrdn_out_t r, input int i);
        return longint'(signed'(r[1 + IO_BITS*(NUM_DIGITS-1-i) +: IO_BITS]));
    endfunction

    function automatic mrdn_out_t step_date(input mrdn_in_t it);
        longint    sum;
        longint    quot;
        longint    carry;
        mrdn_out_t res;
        bit        in_range;
        carry    = 0;
        in_range = 1'b1;
        res      = '0;
        case (it.kind)
            KIND_LOAD: begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    held_digits[i] = DIGIT_BITS'(offset_at(it, i));
                end
            end
            KIND_CARRY: begin
                for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                    sum  = longint'(held_digits[i]) + offset_at(it, i) + carry;
                    quot = sum / radix_at(i);
                    if (sum % radix_at(i) < 0) begin
                        quot = quot - 1;
                    end
                    held_digits[i] = DIGIT_BITS'(sum - quot * radix_at(i));
                    carry = quot;
                end
                held_digits[NUM_DIGITS-1] = DIGIT_BITS'(longint'(held_digits[NUM_DIGITS-1])
                    + offset_at(it, NUM_DIGITS - 1) + carry);
            end
            KIND_CLAMP: begin
                for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                    sum = longint'(held_digits[i]) + offset_at(it, i);
                    if (sum < 0) begin
                        sum = 0;
                    end else if (sum >= radix_at(i)) begin
                        sum = radix_at(i) - 1;
                    end
                    held_digits[i] = DIGIT_BITS'(sum);
                end
                held_digits[NUM_DIGITS-1] = DIGIT_BITS'(longint'(held_digits[NUM_DIGITS-1])
                    + offset_at(it, NUM_DIGITS - 1));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < NUM_DIGITS; i++) begin
            res[1 + IO_BITS*(NUM_DIGITS-1-i) +: IO_BITS] = IO_BITS'(longint'(held_digits[i]));
            if (i < NUM_DIGITS - 1 &&
                (longint'(held_digits[i]) < 0 || longint'(held_digits[i]) >= radix_at(i))) begin
                in_range = 1'b0;
            end
        end
        res.all_in_range = in_range;
        return res;
    endfunction

    task automatic compare_date(input mrdn_out_t want, input mrdn_out_t got);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (want[1 + IO_BITS*(NUM_DIGITS-1-i) +: IO_BITS] !==
                got[1 + IO_BITS*(NUM_DIGITS-1-i) +: IO_BITS]) begin
                $error("%s expected %0d actual %0d", digit_names[i],
                    out_digit(want, i), out_digit(got, i));
                fail_count++;
            end
        end
        if (want.all_in_range !== got.all_in_range) begin
            $error("all_in_range expected %0d actual %0d", want.all_in_range, got.all_in_range);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        mrdn_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                held_digits[i] = '0;
            end
            expected_dates.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    $error("result transfer with no expected date waiting");
                    fail_count++;
                end else begin
                    want = expected_dates.pop_front();
                    compare_date(want, m_item);
                end
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(step_date(s_item));
            end
        end
        pending_results <= expected_dates.size();
    end

endmodule

[dv/mixed_radix_date_normalizer_top_tb.sv]
// testbench top for the mixed-radix date normalizer: clock, reset, stimulus, receiver stalls, verdict
module mixed_radix_date_normalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrdn_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [IO_BITS-1:0] DIGIT_MAX = {1'b0, {(IO_BITS-1){1'b1}}};
    localparam logic signed [IO_BITS-1:0] DIGIT_MIN = {1'b1, {(IO_BITS-1){1'b0}}};
    localparam logic signed [IO_BITS-1:0] DIGIT_NEG = {IO_BITS{1'b1}};
    localparam logic signed [IO_BITS-1:0] DIGIT_ONE = IO_BITS'(1);
    localparam logic signed [IO_BITS-1:0] DIGIT_ZERO = '0;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        m_ready = 1'b0;
    mrdn_in_t    s_item  = '0;
    logic        s_ready;
    logic        m_valid;
    mrdn_out_t   m_item;
    int          pending_results;
    int          fail_count;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int          ready_pct   = 100;
    int          phase_left  = 0;

    mixed_radix_date_normalizer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    mixed_radix_date_normalizer_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mixed_radix_date_normalizer_top regression: fail");
            $finish;
        end
    end

    // receiver stall pattern: phases of varying readiness
    always @(posedge aclk) begin
        if (phase_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                2:       ready_pct = 35;
                default: ready_pct = 8;
            endcase
            phase_left = $urandom_range(20, 400);
        end else begin
            phase_left = phase_left - 1;
        end
        m_ready <= aresetn && ($urandom_range(1, 100) <= ready_pct);
    end

    function automatic logic signed [IO_BITS-1:0] rand_offset();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return IO_BITS'(int'($urandom_range(0, 120)) - 60);
            5:             return IO_BITS'(int'($urandom_range(0, 4000)) - 2000);
            6, 7:          return IO_BITS'($urandom);
            8:             return DIGIT_ZERO;
            9:             return DIGIT_MAX;
            10:            return DIGIT_MIN;
            default:       return IO_BITS'(int'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic mrdn_in_t make_date(input kind_t k, input bit days_only);
        logic signed [IO_BITS-1:0] d [NUM_DIGITS];
        int                        radix;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            radix = (i == 0) ? LOW_RADIX : (i == 1) ? SECOND_RADIX : UPPER_RADIX;
            if (k == KIND_LOAD) begin
                if (i == NUM_DIGITS - 1 || $urandom_range(0, 7) == 0) begin
                    d[i] = rand_offset();
                end else begin
                    d[i] = IO_BITS'($urandom_range(0, radix - 1));
                end
            end else if (days_only && i != 0) begin
                d[i] = DIGIT_ZERO;
            end else begin
                d[i] = rand_offset();
            end
        end
        return {k, d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], d[8]};
    endfunction

    task automatic send_date(input mrdn_in_t it);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_date({KIND_CARRY, {NUM_DIGITS{DIGIT_ZERO}}});
        send_date({KIND_LOAD, {NUM_DIGITS{DIGIT_MAX}}});
        send_date(make_date(KIND_NONE, 1'b0));
        send_date({KIND_CARRY, {NUM_DIGITS{DIGIT_MAX}}});
        send_date({KIND_LOAD, {NUM_DIGITS{DIGIT_MIN}}});
        send_date({KIND_CARRY, {NUM_DIGITS{DIGIT_MIN}}});
        send_date({KIND_CLAMP, {NUM_DIGITS{DIGIT_MAX}}});
        send_date({KIND_CLAMP, {NUM_DIGITS{DIGIT_MIN}}});
        // every lower digit at its top value, then ripple a carry and a borrow through all
        send_date({KIND_LOAD, IO_BITS'(LOW_RADIX - 1), IO_BITS'(SECOND_RADIX - 1),
                   {6{IO_BITS'(UPPER_RADIX - 1)}}, DIGIT_MAX});
        send_date({KIND_CARRY, DIGIT_ONE, {8{DIGIT_ZERO}}});
        send_date({KIND_CARRY, DIGIT_NEG, {8{DIGIT_ZERO}}});
        send_date({KIND_CLAMP, {8{DIGIT_ZERO}}, DIGIT_ONE});
        send_date({KIND_LOAD, IO_BITS'(LOW_RADIX), IO_BITS'(SECOND_RADIX), IO_BITS'(UPPER_RADIX),
                   DIGIT_NEG, IO_BITS'(UPPER_RADIX), DIGIT_NEG, IO_BITS'(UPPER_RADIX),
                   DIGIT_NEG, DIGIT_MIN});
        send_date({KIND_NONE, {NUM_DIGITS{DIGIT_NEG}}});
        send_date({KIND_CLAMP, {NUM_DIGITS{DIGIT_ZERO}}});
        send_date({KIND_LOAD, {NUM_DIGITS{DIGIT_ZERO}}});
        send_date({KIND_CARRY, DIGIT_MAX, {8{DIGIT_ZERO}}});
        send_date({KIND_CARRY, DIGIT_MIN, {8{DIGIT_ZERO}}});
        send_date({KIND_CARRY, DIGIT_MIN, {8{DIGIT_ZERO}}});
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_date(make_date(KIND_LOAD, 1'b0));
            end else if (pick < 50) begin
                send_date(make_date(KIND_CARRY, 1'b0));
            end else if (pick < 62) begin
                send_date(make_date(KIND_CARRY, 1'b1));
            end else if (pick < 90) begin
                send_date(make_date(KIND_CLAMP, 1'b0));
            end else begin
                send_date(make_date(KIND_NONE, 1'b0));
            end
            if (n % 400 == 399) begin
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("mixed_radix_date_normalizer_top regression: pass");
        end else begin
            $display("mixed_radix_date_normalizer_top regression: fail");
        end
        $finish;
    end

endmodule
